// File: rtl/core/rhsv_pkg.sv
// rhsv_pkg: widths, scale constants and word types shared by the rgb to hsv converter
// no dependencies; every file in rtl/core but rhsv_fifo refers to it by scoped names
`timescale 1ns / 1ps

package rhsv_pkg;

  localparam int CH_W  = 8;   // one color channel
  localparam int VAL_W = 15;  // hue, saturation and value words
  localparam int DVD_W = 23;  // widest dividend, spread * 25600
  localparam int DVS_W = 8;   // divisor, spread or max channel
  localparam int QUO_W = 15;  // quotient bits, one per divider stage

  // hue scale: 60 degrees in 1/64 degree units
  localparam logic [11:0] HUE_SECTOR = 12'd3840;
  // saturation scale: 100 percent in 1/256 percent units
  localparam logic [14:0] SAT_SCALE  = 15'd25600;
  // value scale: 100 * max / 256 percent in 1/256 units is 100 * max
  localparam logic [6:0]  VAL_SCALE  = 7'd100;

  // sector offsets in 1/64 degree
  localparam logic [VAL_W-1:0] BASE_RED   = 15'd0;
  localparam logic [VAL_W-1:0] BASE_GREEN = 15'd7680;
  localparam logic [VAL_W-1:0] BASE_BLUE  = 15'd15360;
  localparam logic [VAL_W-1:0] FULL_TURN  = 15'd23040;

  // classified pixel, handed from the front part to the back part
  typedef struct packed {
    logic [DVD_W-1:0] hue_dvd;
    logic [DVS_W-1:0] hue_dvs;
    logic [DVD_W-1:0] sat_dvd;
    logic [DVS_W-1:0] sat_dvs;
    logic [VAL_W-1:0] hue_base;
    logic             hue_neg;
    logic [VAL_W-1:0] bright;
  } work_t;

  // fields that ride alongside the dividers
  typedef struct packed {
    logic [VAL_W-1:0] hue_base;
    logic             hue_neg;
    logic [VAL_W-1:0] bright;
  } tag_t;

  // finished result word
  typedef struct packed {
    logic [VAL_W-1:0] hue;
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] bright;
  } hsv_t;

endpackage

// File: rtl/core/rgb_to_hsv_pixel.sv
// rgb_to_hsv_pixel: top level of the rgb to hsv pixel converter
// depends on rhsv_pkg, rhsv_fifo, rhsv_front, rhsv_div and rhsv_back
`timescale 1ns / 1ps

// usage
//  - input channel is a queue write port: drive in_red/in_green/in_blue and raise
//    in_push; the word is taken at a clock edge where in_full is low
//  - result channel is a queue read port: while out_empty is low the oldest result
//    sits on out_hue/out_saturation/out_brightness; raise out_pop to take it
//  - hue in 1/64 degree (0..23039), saturation and value in 1/256 percent
//  - front part: one register stage that finds max/min and the hue sector and
//    forms the divider operands, then a short queue (MID_DEPTH words)
//  - back part: two 15-stage restoring dividers, one quotient bit per stage,
//    then the result queue (OUT_DEPTH words)
//  - path: from the accepting edge to out_empty going low, a word passes
//    the front register, the middle queue, the 15 divider stages and the result queue
//  - throughput: one word per cycle, back to back, while out_pop keeps up
//  - receiver stall: words pile up in the result queue, then the divider line
//    freezes, then the middle queue fills, and finally in_full rises
//  - reset (rst_n low, synchronous) empties both queues and the divider line;
//    no stored state survives, every word is converted on its own
module rgb_to_hsv_pixel #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [rhsv_pkg::CH_W-1:0]    in_red,
  input  logic [rhsv_pkg::CH_W-1:0]    in_green,
  input  logic [rhsv_pkg::CH_W-1:0]    in_blue,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [rhsv_pkg::VAL_W-1:0]   out_hue,
  output logic [rhsv_pkg::VAL_W-1:0]   out_saturation,
  output logic [rhsv_pkg::VAL_W-1:0]   out_brightness
);

  // front to middle queue
  logic            mid_push, mid_full, mid_pop, mid_empty;
  rhsv_pkg::work_t mid_wr_word, mid_rd_word;

  // back to result queue
  logic            res_push, res_full;
  rhsv_pkg::hsv_t  res_wr_word, res_rd_word;

  rhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .mid_push (mid_push),
    .mid_word (mid_wr_word),
    .mid_full (mid_full)
  );

  // decouples classification from the divider line
  rhsv_fifo #(
    .WIDTH ($bits(rhsv_pkg::work_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr_word),
    .pop   (mid_pop),
    .rdata (mid_rd_word),
    .full  (mid_full),
    .empty (mid_empty)
  );

  rhsv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_word  (mid_rd_word),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_push  (res_push),
    .out_word  (res_wr_word),
    .out_full  (res_full)
  );

  // result queue keeps the divider line running while the receiver hesitates
  rhsv_fifo #(
    .WIDTH ($bits(rhsv_pkg::hsv_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wr_word),
    .pop   (out_pop),
    .rdata (res_rd_word),
    .full  (res_full),
    .empty (out_empty)
  );

  assign out_hue        = res_rd_word.hue;
  assign out_saturation = res_rd_word.sat;
  assign out_brightness = res_rd_word.bright;

endmodule

// File: rtl/core/rhsv_fifo.sv
// rhsv_fifo: small synchronous queue of register entries
// standalone; used between front and back and on the result side
`timescale 1ns / 1ps

module rhsv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo count beyond depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !empty)
    else $error("fifo empty right after a push");

endmodule

// File: rtl/core/rhsv_front.sv
// rhsv_front: takes pixels, finds max, min and hue sector, builds divider operands
// depends on rhsv_pkg
`timescale 1ns / 1ps

module rhsv_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [rhsv_pkg::CH_W-1:0]    in_red,
  input  logic [rhsv_pkg::CH_W-1:0]    in_green,
  input  logic [rhsv_pkg::CH_W-1:0]    in_blue,
  output logic                         mid_push,
  output rhsv_pkg::work_t              mid_word,
  input  logic                         mid_full
);

  localparam int CH_W  = rhsv_pkg::CH_W;
  localparam int DVD_W = rhsv_pkg::DVD_W;
  localparam int VAL_W = rhsv_pkg::VAL_W;

  logic            fr_vld_r, fr_vld_nxt;
  rhsv_pkg::work_t fr_word_r, fr_word_nxt;
  logic            load;

  logic [CH_W-1:0] mx, mn, d, p, q, x;
  logic            neg;

  assign in_full  = fr_vld_r && mid_full;
  assign load     = in_push && !in_full;
  assign mid_push = fr_vld_r && !mid_full;
  assign mid_word = fr_word_r;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    d = mx - mn;

    // red wins ties, then green
    if (in_red == mx) begin
      p = in_green;
      q = in_blue;
      fr_word_nxt.hue_base = rhsv_pkg::BASE_RED;
    end else if (in_green == mx) begin
      p = in_blue;
      q = in_red;
      fr_word_nxt.hue_base = rhsv_pkg::BASE_GREEN;
    end else begin
      p = in_red;
      q = in_green;
      fr_word_nxt.hue_base = rhsv_pkg::BASE_BLUE;
    end
    neg = (p < q);
    x   = neg ? (q - p) : (p - q);
    // negative red sector wraps by a full turn
    if (neg && (in_red == mx)) begin
      fr_word_nxt.hue_base = rhsv_pkg::FULL_TURN;
    end

    fr_word_nxt.hue_neg = neg;
    fr_word_nxt.hue_dvd = DVD_W'(x) * DVD_W'(rhsv_pkg::HUE_SECTOR);
    fr_word_nxt.hue_dvs = (d == '0) ? CH_W'(1) : d;
    fr_word_nxt.sat_dvd = DVD_W'(d) * DVD_W'(rhsv_pkg::SAT_SCALE);
    fr_word_nxt.sat_dvs = (mx == '0) ? CH_W'(1) : mx;
    fr_word_nxt.bright  = VAL_W'(mx) * VAL_W'(rhsv_pkg::VAL_SCALE);

    fr_vld_nxt = load || (fr_vld_r && mid_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      fr_word_r <= fr_word_nxt;
    end
  end

endmodule

// File: rtl/core/rhsv_div.sv
// rhsv_div: pipelined restoring divider, one quotient bit per stage
// depends on rhsv_pkg; dividend must stay below divisor * 2^QUO_W
`timescale 1ns / 1ps

module rhsv_div (
  input  logic                         clk,
  input  logic                         en,
  input  logic [rhsv_pkg::DVD_W-1:0]   dividend,
  input  logic [rhsv_pkg::DVS_W-1:0]   divisor,
  output logic [rhsv_pkg::QUO_W-1:0]   quotient,
  output logic                         rem_nz
);

  localparam int DVD_W = rhsv_pkg::DVD_W;
  localparam int DVS_W = rhsv_pkg::DVS_W;
  localparam int QUO_W = rhsv_pkg::QUO_W;

  logic [DVD_W-1:0] rem_r   [QUO_W];
  logic [DVS_W-1:0] dvs_r   [QUO_W];
  logic [QUO_W-1:0] quo_r   [QUO_W];
  logic [DVD_W-1:0] rem_in  [QUO_W];
  logic [DVS_W-1:0] dvs_in  [QUO_W];
  logic [QUO_W-1:0] quo_in  [QUO_W];
  logic [DVD_W-1:0] rem_nxt [QUO_W];
  logic [QUO_W-1:0] quo_nxt [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;  // quotient bit settled here
    logic [DVD_W-1:0] shd;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in[s] = dividend;
      assign dvs_in[s] = divisor;
      assign quo_in[s] = '0;
    end else begin : g_next
      assign rem_in[s] = rem_r[s-1];
      assign dvs_in[s] = dvs_r[s-1];
      assign quo_in[s] = quo_r[s-1];
    end

    assign shd        = DVD_W'(dvs_in[s]) << K;
    assign ge         = (rem_in[s] >= shd);
    assign rem_nxt[s] = ge ? (rem_in[s] - shd) : rem_in[s];
    assign quo_nxt[s] = quo_in[s] | (QUO_W'(ge) << K);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QUO_W; s++) begin
        rem_r[s] <= rem_nxt[s];
        dvs_r[s] <= dvs_in[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quotient = quo_r[QUO_W-1];
  assign rem_nz   = |rem_r[QUO_W-1];

endmodule

// File: rtl/core/rhsv_back.sv
// rhsv_back: runs hue and saturation divisions in lockstep and assembles results
// depends on rhsv_pkg and rhsv_div
`timescale 1ns / 1ps

module rhsv_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rhsv_pkg::work_t mid_word,
  input  logic            mid_empty,
  output logic            mid_pop,
  output logic            out_push,
  output rhsv_pkg::hsv_t  out_word,
  input  logic            out_full
);

  localparam int VAL_W = rhsv_pkg::VAL_W;
  localparam int QUO_W = rhsv_pkg::QUO_W;
  localparam int LAST  = QUO_W - 1;

  logic           vld_r [QUO_W];
  rhsv_pkg::tag_t tag_r [QUO_W];
  rhsv_pkg::tag_t tag_in;
  logic           advance;

  logic [QUO_W-1:0] hue_q, sat_q;
  logic             hue_rnz, sat_rnz;
  logic [VAL_W:0]   hue_sum;

  // whole line moves unless a finished word is stuck at the end
  assign advance  = !vld_r[LAST] || !out_full;
  assign mid_pop  = advance && !mid_empty;
  assign out_push = vld_r[LAST] && !out_full;

  assign tag_in.hue_base = mid_word.hue_base;
  assign tag_in.hue_neg  = mid_word.hue_neg;
  assign tag_in.bright   = mid_word.bright;

  rhsv_div u_hue_div (
    .clk      (clk),
    .en       (advance),
    .dividend (mid_word.hue_dvd),
    .divisor  (mid_word.hue_dvs),
    .quotient (hue_q),
    .rem_nz   (hue_rnz)
  );

  rhsv_div u_sat_div (
    .clk      (clk),
    .en       (advance),
    .dividend (mid_word.sat_dvd),
    .divisor  (mid_word.sat_dvs),
    .quotient (sat_q),
    .rem_nz   (sat_rnz)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QUO_W; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (advance) begin
      vld_r[0] <= mid_pop;
      for (int s = 1; s < QUO_W; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_r[0] <= tag_in;
      for (int s = 1; s < QUO_W; s++) begin
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  // negative offsets round toward the lower hue: subtract the ceiling
  always_comb begin
    if (tag_r[LAST].hue_neg) begin
      hue_sum = (VAL_W+1)'(tag_r[LAST].hue_base) - (VAL_W+1)'(hue_q)
              - (VAL_W+1)'(hue_rnz);
    end else begin
      hue_sum = (VAL_W+1)'(tag_r[LAST].hue_base) + (VAL_W+1)'(hue_q);
    end
    out_word.hue    = VAL_W'(hue_sum);
    out_word.sat    = VAL_W'(sat_q);
    out_word.bright = tag_r[LAST].bright;
  end

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |=> vld_r[0])
    else $error("popped word did not enter the divider line");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && out_full) |=> (vld_r[LAST] && $stable(out_word)))
    else $error("stalled result word changed or vanished");

  // full saturation only when spread equals max, which divides exactly
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[LAST] && (sat_q == rhsv_pkg::SAT_SCALE)) |-> !sat_rnz)
    else $error("full saturation with a nonzero remainder");

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for the rgb_to_hsv_pixel converter
// depends on rhsv_pkg and rgb_to_hsv_pixel; predicts each hsv word from its pixel
`timescale 1ns / 1ps

module testbench;

  // hsv scale factors, 1/64 degree for hue and 1/256 percent for sat and value
  localparam int unsigned HUE_DEG    = 64;
  localparam int unsigned HUE_SIXTY  = 60 * HUE_DEG;
  localparam int unsigned HUE_TURN   = 360 * HUE_DEG;
  localparam int unsigned PCT_FULL   = 100 * 256;
  localparam int unsigned RAND_WORDS = 400;
  // nothing accepted on either side for this long means the block is stuck
  localparam int unsigned IDLE_LIMIT = 2000;
  // drain time after the last result, so a stray extra word still reaches the monitor
  localparam int unsigned DRAIN_CYCLES = 40;

  localparam int CH_W = rhsv_pkg::CH_W;

  typedef struct packed {
    logic [rhsv_pkg::CH_W-1:0] red;
    logic [rhsv_pkg::CH_W-1:0] green;
    logic [rhsv_pkg::CH_W-1:0] blue;
  } pixel_t;

  // receiver behavior, redrawn when the current mode runs out
  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_HOLD,
    POP_COIN,
    POP_THIRD
  } pop_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_push = 1'b0;
  logic                        in_full;
  logic [rhsv_pkg::CH_W-1:0]   in_red = '0;
  logic [rhsv_pkg::CH_W-1:0]   in_green = '0;
  logic [rhsv_pkg::CH_W-1:0]   in_blue = '0;
  logic                        out_empty;
  logic                        out_pop = 1'b0;
  logic [rhsv_pkg::VAL_W-1:0]  out_hue;
  logic [rhsv_pkg::VAL_W-1:0]  out_saturation;
  logic [rhsv_pkg::VAL_W-1:0]  out_brightness;

  // pixels waiting to be pushed; the head is the one on the input ports
  pixel_t          pixel_q[$];
  // predicted hsv words, oldest first
  rhsv_pkg::hsv_t  hsv_expected[$];
  int unsigned     mismatches = 0;
  int unsigned     idle_cycles = 0;

  // sender burst / gap bookkeeping
  int unsigned     burst_left = 0;
  int unsigned     gap_left = 0;

  // receiver stall pattern
  pop_mode_t       pop_mode = POP_ALWAYS;
  int unsigned     mode_left = 0;
  int unsigned     pop_phase = 0;

  rgb_to_hsv_pixel dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hsv of one pixel: sector hue, spread over max saturation, 100 * max value
  function automatic rhsv_pkg::hsv_t hsv_of_pixel(pixel_t px);
    int unsigned    r, g, b;
    int unsigned    top, bottom, spread;
    int unsigned    base, hi, lo, num, quo;
    rhsv_pkg::hsv_t word;
    r = 32'(px.red);
    g = 32'(px.green);
    b = 32'(px.blue);
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    spread = top - bottom;
    word = '0;
    // grey pixels (spread zero) keep hue 0
    if (spread != 0) begin
      // red is tested first, then green, so ties go to the earlier channel
      if (r == top) begin
        base = 0;
        hi = g;
        lo = b;
      end else if (g == top) begin
        base = 120 * HUE_DEG;
        hi = b;
        lo = r;
      end else begin
        base = 240 * HUE_DEG;
        hi = r;
        lo = g;
      end
      if (hi >= lo) begin
        num = base * spread + (hi - lo) * HUE_SIXTY;
      end else if (base != 0) begin
        num = base * spread - (lo - hi) * HUE_SIXTY;
      end else begin
        // red sector below zero wraps by a full turn before the floor
        num = HUE_TURN * spread - (lo - hi) * HUE_SIXTY;
      end
      quo = num / spread;
      word.hue = quo[rhsv_pkg::VAL_W-1:0];
    end
    // black pixel keeps saturation 0
    if (top != 0) begin
      quo = (spread * PCT_FULL) / top;
      word.sat = quo[rhsv_pkg::VAL_W-1:0];
    end
    quo = 100 * top;
    word.bright = quo[rhsv_pkg::VAL_W-1:0];
    return word;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic queue_pixel(int unsigned r, int unsigned g, int unsigned b);
    pixel_t px;
    px.red = r[rhsv_pkg::CH_W-1:0];
    px.green = g[rhsv_pkg::CH_W-1:0];
    px.blue = b[rhsv_pkg::CH_W-1:0];
    pixel_q.push_back(px);
  endtask

  // channel near a level, kept inside 0..255
  function automatic logic [rhsv_pkg::CH_W-1:0] near_level(int unsigned lvl);
    int unsigned v;
    v = (lvl > 250) ? lvl - $urandom_range(0, 4) : lvl + $urandom_range(0, 4);
    return CH_W'(v);
  endfunction

  // random pixel, weighted toward ties, small spreads and the channel extremes
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned lvl, lvl2;
    lvl = $urandom_range(0, 255);
    lvl2 = $urandom_range(0, 255);
    px.red = CH_W'($urandom_range(0, 255));
    px.green = CH_W'($urandom_range(0, 255));
    px.blue = CH_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // fully random, nothing to adjust
      end
      4: begin
        // near grey: channels within a few codes of each other
        px.red = near_level(lvl);
        px.green = near_level(lvl);
        px.blue = near_level(lvl);
      end
      5: begin
        // two channels tie for the max
        case ($urandom_range(0, 2))
          0: begin
            px.red = CH_W'(lvl);
            px.green = CH_W'(lvl);
            px.blue = CH_W'($urandom_range(0, lvl));
          end
          1: begin
            px.green = CH_W'(lvl);
            px.blue = CH_W'(lvl);
            px.red = CH_W'($urandom_range(0, lvl));
          end
          default: begin
            px.red = CH_W'(lvl);
            px.blue = CH_W'(lvl);
            px.green = CH_W'($urandom_range(0, lvl));
          end
        endcase
      end
      6: begin
        // red on top with blue above green, the wrapping hue
        if (lvl < lvl2) begin
          px.red = CH_W'(lvl2);
          px.blue = CH_W'($urandom_range(lvl, lvl2));
          px.green = CH_W'(lvl);
        end else begin
          px.red = CH_W'(lvl);
          px.blue = CH_W'($urandom_range(lvl2, lvl));
          px.green = CH_W'(lvl2);
        end
      end
      7: begin
        // channels pinned at the extremes
        px.red = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        px.green = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        px.blue = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
      end
      8: begin
        // grey
        px.red = CH_W'(lvl);
        px.green = CH_W'(lvl);
        px.blue = CH_W'(lvl);
      end
      default: begin
        // dark pixels, small max
        px.red = CH_W'($urandom_range(0, 3));
        px.green = CH_W'($urandom_range(0, 3));
        px.blue = CH_W'($urandom_range(0, 3));
      end
    endcase
    return px;
  endfunction

  // driver: bursts of words from pixel_q with random gaps in between
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      // word taken at this edge: predict it and drop it from the pending list
      if (in_push && !in_full) begin
        hsv_expected.push_back(hsv_of_pixel(pixel_q[0]));
        void'(pixel_q.pop_front());
      end
      // a word held against in_full stays on the ports untouched
      if (!(in_push && in_full)) begin
        if (burst_left == 0 && gap_left == 0) begin
          // now and then a long burst, and now and then no gap after a burst
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120)
                                                   : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (burst_left != 0 && pixel_q.size() != 0) begin
          in_red <= pixel_q[0].red;
          in_green <= pixel_q[0].green;
          in_blue <= pixel_q[0].blue;
          in_push <= 1'b1;
          burst_left--;
        end else begin
          in_push <= 1'b0;
          if (burst_left == 0 && gap_left != 0) gap_left--;
        end
      end
    end
  end

  // monitor: checks every popped word against the oldest prediction
  always @(posedge clk) begin
    rhsv_pkg::hsv_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (hsv_expected.size() == 0) begin
          report_mismatch("unexpected word, hue", 32'(out_hue), 0);
        end else begin
          want = hsv_expected.pop_front();
          if (out_hue !== want.hue)
            report_mismatch("hue", 32'(out_hue), 32'(want.hue));
          if (out_saturation !== want.sat)
            report_mismatch("saturation", 32'(out_saturation), 32'(want.sat));
          if (out_brightness !== want.bright)
            report_mismatch("brightness", 32'(out_brightness), 32'(want.bright));
        end
      end
      // receiver pattern: a mode holds for a random stretch, then another is drawn
      if (mode_left == 0) begin
        pop_mode = pop_mode_t'($urandom_range(0, 3));
        mode_left = (pop_mode == POP_HOLD) ? $urandom_range(5, 40) : $urandom_range(10, 60);
      end
      mode_left--;
      pop_phase++;
      case (pop_mode)
        POP_ALWAYS: out_pop <= 1'b1;
        POP_HOLD:   out_pop <= 1'b0;
        POP_COIN:   out_pop <= ($urandom_range(0, 1) != 0);
        default:    out_pop <= (pop_phase % 3 == 0);
      endcase
    end
  end

  // watchdog: counts cycles with no word taken on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rgb_to_hsv_pixel verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // directed: black, white, greys, primaries, ties, the wrapping red hue
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(1, 1, 1);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 0, 1);
    queue_pixel(255, 1, 0);
    queue_pixel(200, 50, 199);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 1, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(255, 254, 253);
    queue_pixel(100, 200, 50);
    queue_pixel(50, 200, 100);
    queue_pixel(50, 100, 200);
    queue_pixel(100, 50, 200);
    queue_pixel(170, 85, 255);
    for (int i = 0; i < RAND_WORDS; i++) pixel_q.push_back(random_pixel());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every pixel taken and every word popped, then let the pipe drain
    while (pixel_q.size() != 0 || hsv_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hsv_expected.size() != 0) report_mismatch("words left over", hsv_expected.size(), 0);

    if (mismatches == 0) begin
      $display("rgb_to_hsv_pixel verification clean");
    end else begin
      $display("rgb_to_hsv_pixel verification failed");
    end
    $finish;
  end

endmodule

// File: rgb_to_hsv_pixel.f
rtl/core/rhsv_pkg.sv
rtl/core/rhsv_fifo.sv
rtl/core/rhsv_front.sv
rtl/core/rhsv_div.sv
rtl/core/rhsv_back.sv
rtl/core/rgb_to_hsv_pixel.sv
test/testbench.sv
